// ===== rtl/core/pulse_counter_with_freq_meter_assert.svh =====
// Assertion helpers for the pulse counter, sampled on clk, idle during reset.
`ifndef PULSE_COUNTER_WITH_FREQ_METER_ASSERT_SVH
`define PULSE_COUNTER_WITH_FREQ_METER_ASSERT_SVH

// Same-cycle implication.
`define PCFM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcfm: same-cycle check failed");

// Next-cycle implication.
`define PCFM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcfm: next-cycle check failed");

`endif

// ===== rtl/core/pcfm_pkg.sv =====
// ---------------------------------------------------------------------------
// pcfm_pkg
// Types, codes and constants shared by the pulse counter modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package pcfm_pkg;

  localparam int MAX_COUNT_BITS = 64;
  localparam int CFG_IDX_W      = 3;
  localparam int DIV_BITS       = 27;
  localparam int DIVISOR_W      = 11;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_ENABLED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_SELECT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_DOWN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_CODE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE_DIV    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_START_VALUE     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_ENABLE     = 3'd7;

  // Command bits
  localparam int CMD_RESET = 0;
  localparam int CMD_START = 1;
  localparam int CMD_STOP  = 2;

  // Edge codes
  localparam logic [1:0] EDGE_RISE = 2'd0;
  localparam logic [1:0] EDGE_FALL = 2'd1;
  localparam logic [1:0] EDGE_BOTH = 2'd2;

  localparam logic [1:0]  WIDTH_RESET = 2'd2;
  localparam logic [14:0] FREQ_MAX    = 15'd20000;
  localparam logic [63:0] DELTA_MAX   = 64'd100000;
  localparam logic [31:0] WIN_MIN     = 32'd1000;
  localparam logic [31:0] WIN_MAX     = 32'd2000;
  localparam logic [31:0] WIN_STALE   = 32'd5000;
  localparam logic [9:0]  MS_PER_S    = 10'd1000;

  typedef struct packed {
    logic        level;
    logic [31:0] now_ms;
    logic [2:0]  command;
  } pcfm_in_t;

  typedef struct packed {
    logic [63:0] count_value;
    logic        overflow_flag;
    logic [14:0] freq_hz;
    logic        is_running;
  } pcfm_out_t;

  typedef struct packed {
    logic ld_in;
    logic step;
    logic freq;
    logic check;
    logic mul;
    logic div_start;
    logic ld_freq;
    logic ld_out;
  } pcfm_cmd_t;

  typedef struct packed {
    logic go_freq;
    logic go_div;
    logic div_done;
  } pcfm_sts_t;

  // Counter mask for a width code, capped at maxb bits.
  function automatic logic [63:0] width_mask(input logic [1:0] code, input int maxb);
    int          bits;
    logic [63:0] m;
    bits = 8 << code;
    if (bits > maxb) bits = maxb;
    for (int i = 0; i < 64; i++) m[i] = (i < bits);
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/pulse_counter_with_freq_meter.sv =====
// ---------------------------------------------------------------------------
// pulse_counter_with_freq_meter
// Polled pulse counter channel with debounce, prescaler and frequency meter.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, in_data): one poll beat carries the
//   sampled level, a millisecond timestamp and the reset/start/stop bits.
//   Output channel (out_valid/out_ready, out_data): exactly one result beat
//   per poll with count, sticky overflow, frequency and run state.
//   Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready,
//   write only while the block is idle.
//   Sequence: a poll that steps no count, or steps it with the meter off,
//   goes from the step state to the result; one that runs the frequency
//   window adds the window and check states, and one that divides adds the
//   multiply and the bit-serial divider (27 quotient bits, one per cycle).
//   One poll is in work at a time; the next is taken after its result.
//   Reset: registers take their defaults, the count, run, overflow and
//   window state clears, no result is pending.
//   Stall: the result register holds its beat while out_ready is low; the
//   next poll may be accepted and worked, then waits for the register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "pulse_counter_with_freq_meter_assert.svh"
module pulse_counter_with_freq_meter #(
  parameter int MAX_COUNT_BITS = pcfm_pkg::MAX_COUNT_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire pcfm_pkg::pcfm_in_t             in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output pcfm_pkg::pcfm_out_t                 out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [pcfm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]                    cfg_data
);
  import pcfm_pkg::*;

  pcfm_cmd_t cmd;
  pcfm_sts_t sts;

  // Configuration writes go straight into registers, so never stall them.
  assign cfg_ready = 1'b1;

  pcfm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pcfm_dp #(
    .MAXB (MAX_COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

  // No new poll is taken while one is in work.
  `PCFM_ASSERT_NEXT(a_one_in_work, in_valid && in_ready, !in_ready)
  // Result beats only load into a free slot.
  `PCFM_ASSERT_NOW(a_load_free, cmd.ld_out, !out_valid || out_ready)
  // Frequency is clamped on every delivered beat.
  `PCFM_ASSERT_NOW(a_freq_clamp, out_valid, out_data.freq_hz <= FREQ_MAX)

endmodule
`default_nettype wire

// ===== rtl/core/pcfm_div.sv =====
// ---------------------------------------------------------------------------
// pcfm_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pcfm_div (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [pcfm_pkg::DIV_BITS-1:0]  dividend,
  input  wire logic [pcfm_pkg::DIVISOR_W-1:0] divisor,
  output logic                                done,
  output logic [pcfm_pkg::DIV_BITS-1:0]       quotient
);
  import pcfm_pkg::*;

  localparam int CNT_W = $clog2(DIV_BITS + 1);

  logic [DIV_BITS-1:0]  q_r, q_nxt;
  logic [DIVISOR_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   shifted;

  always_comb begin
    shifted  = {rem_r, q_r[DIV_BITS-1]};
    trial    = shifted - {1'b0, divisor};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(DIV_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // keep the partial remainder below the divisor
      if (!trial[DIVISOR_W]) begin
        rem_nxt = trial[DIVISOR_W-1:0];
        q_nxt   = {q_r[DIV_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DIVISOR_W-1:0];
        q_nxt   = {q_r[DIV_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;
endmodule
`default_nettype wire

// ===== rtl/core/pcfm_dp.sv =====
// ---------------------------------------------------------------------------
// pcfm_dp
// Counter datapath: configuration, edge and prescale logic, frequency window.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pcfm_dp #(
  parameter int MAXB = pcfm_pkg::MAX_COUNT_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [pcfm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]                    cfg_data,
  input  wire pcfm_pkg::pcfm_in_t             in_data,
  input  wire pcfm_pkg::pcfm_cmd_t            cmd,
  output pcfm_pkg::pcfm_sts_t                 sts,
  output pcfm_pkg::pcfm_out_t                 out_data
);
  import pcfm_pkg::*;

  // configuration
  logic        en_r, down_r, fen_r;
  logic [1:0]  edge_r, wcode_r;
  logic [7:0]  pdiv_r;
  logic [63:0] start_r;
  logic [15:0] dbnc_r;

  // channel state
  pcfm_in_t         in_r;
  logic [MAXB-1:0]  count_r, count_nxt;
  logic [7:0]       pcnt_r, pcnt_nxt;
  logic             prev_r, prev_nxt;
  logic [31:0]      last_r, last_nxt;
  logic             run_r, run_nxt;
  logic             ovf_r, ovf_nxt;
  logic [31:0]      wsms_r, wsms_nxt;
  logic [63:0]      wscnt_r, wscnt_nxt;
  logic [14:0]      freq_r, freq_nxt;
  logic [63:0]      delta_r, delta_nxt;
  logic             wrap_r, wrap_nxt;
  logic             inwin_r, inwin_nxt;
  logic             stale_r, stale_nxt;
  logic [DIVISOR_W-1:0] dt_r, dt_nxt;
  logic [DIV_BITS-1:0]  prod_r, prod_nxt;
  pcfm_out_t        out_r;

  logic [63:0]     mask64;
  logic [MAXB-1:0] mask, start_m, c, cnt1;
  logic [63:0]     count64, wsc0;
  logic [31:0]     wsm0, dt;
  logic [7:0]      pre_eff, pcnt_inc, pcnt1;
  logic            run1, fire, db_ok, stepped, go_freq, go_div, ok;
  logic            div_done;
  logic [DIV_BITS-1:0] quot;

  assign mask64  = width_mask(wcode_r, MAXB);
  assign mask    = mask64[MAXB-1:0];
  assign start_m = start_r[MAXB-1:0] & mask;
  assign count64 = 64'(count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r    <= 1'b0;
      edge_r  <= EDGE_RISE;
      down_r  <= 1'b0;
      wcode_r <= WIDTH_RESET;
      pdiv_r  <= 8'd1;
      start_r <= '0;
      dbnc_r  <= '0;
      fen_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CHANNEL_ENABLED: en_r    <= cfg_data[0];
        CFG_EDGE_SELECT:     edge_r  <= cfg_data[1:0];
        CFG_COUNT_DOWN:      down_r  <= cfg_data[0];
        CFG_WIDTH_CODE:      wcode_r <= cfg_data[1:0];
        CFG_PRESCALE_DIV:    pdiv_r  <= cfg_data[7:0];
        CFG_START_VALUE:     start_r <= cfg_data;
        CFG_DEBOUNCE_MS:     dbnc_r  <= cfg_data[15:0];
        CFG_FREQ_ENABLE:     fen_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    count_nxt = count_r;
    pcnt_nxt  = pcnt_r;
    prev_nxt  = prev_r;
    last_nxt  = last_r;
    run_nxt   = run_r;
    ovf_nxt   = ovf_r;
    wsms_nxt  = wsms_r;
    wscnt_nxt = wscnt_r;
    freq_nxt  = freq_r;
    delta_nxt = delta_r;
    wrap_nxt  = wrap_r;
    inwin_nxt = inwin_r;
    stale_nxt = stale_r;
    dt_nxt    = dt_r;
    prod_nxt  = prod_r;
    go_freq   = 1'b0;
    go_div    = 1'b0;
    ok        = 1'b0;
    stepped   = 1'b0;
    fire      = 1'b0;
    c         = '0;
    run1      = run_r;
    cnt1      = count_r;
    pcnt1     = pcnt_r;
    pre_eff   = (pdiv_r == 8'd0) ? 8'd1 : pdiv_r;
    pcnt_inc  = '0;
    db_ok     = (dbnc_r == 16'd0) || ((in_r.now_ms - last_r) >= {16'd0, dbnc_r});
    wsm0      = (wsms_r == 32'd0) ? in_r.now_ms : wsms_r;
    wsc0      = (wsms_r == 32'd0) ? count64 : wscnt_r;
    dt        = in_r.now_ms - wsm0;

    if (cmd.step && en_r) begin
      if (in_r.command[CMD_RESET]) begin
        cnt1      = start_m;
        pcnt1     = '0;
        ovf_nxt   = 1'b0;
        wsms_nxt  = '0;
        wscnt_nxt = '0;
        freq_nxt  = '0;
      end
      if (in_r.command[CMD_START]) run1 = 1'b1;
      if (in_r.command[CMD_STOP])  run1 = 1'b0;
      run_nxt   = run1;
      count_nxt = cnt1;
      pcnt_nxt  = pcnt1;
      prev_nxt  = in_r.level;
      if (run1) begin
        case (edge_r)
          EDGE_FALL: fire = prev_r && !in_r.level;
          EDGE_BOTH: fire = prev_r != in_r.level;
          default:   fire = !prev_r && in_r.level;
        endcase
        if (fire && db_ok) begin
          last_nxt = in_r.now_ms;
          pcnt_inc = pcnt1 + 8'd1;
          pcnt_nxt = pcnt_inc;
          if (pcnt_inc >= pre_eff) begin
            pcnt_nxt = '0;
            stepped  = 1'b1;
            c        = cnt1 & mask;
            if (down_r ? (c == '0) : (c == mask)) begin
              // leave the range: flag, reload, drop the window
              ovf_nxt   = 1'b1;
              count_nxt = start_m;
              wsms_nxt  = '0;
              wscnt_nxt = '0;
              freq_nxt  = '0;
            end else begin
              count_nxt = down_r ? c - 1'b1 : c + 1'b1;
            end
          end
        end
      end
      go_freq = stepped && fen_r;
    end

    if (cmd.freq) begin
      if (wsms_r == 32'd0) begin
        wsms_nxt  = in_r.now_ms;
        wscnt_nxt = count64;
        freq_nxt  = '0;
      end
      inwin_nxt = (dt >= WIN_MIN) && (dt <= WIN_MAX);
      stale_nxt = dt > WIN_STALE;
      dt_nxt    = dt[DIVISOR_W-1:0];
      if (count64 >= wsc0) begin
        delta_nxt = count64 - wsc0;
        wrap_nxt  = 1'b0;
      end else begin
        delta_nxt = (mask64 - wsc0) + count64 + 64'd1;
        wrap_nxt  = 1'b1;
      end
    end

    if (cmd.check) begin
      ok = !(wrap_r && (delta_r > (mask64 >> 1)));
      if (inwin_r) begin
        go_div    = ok && (delta_r <= DELTA_MAX);
        wsms_nxt  = in_r.now_ms;
        wscnt_nxt = count64;
      end else if (stale_r) begin
        wsms_nxt  = in_r.now_ms;
        wscnt_nxt = count64;
        freq_nxt  = '0;
      end
    end

    if (cmd.mul) prod_nxt = DIV_BITS'(delta_r[16:0]) * DIV_BITS'(MS_PER_S);

    if (cmd.ld_freq) freq_nxt = (quot > DIV_BITS'(FREQ_MAX)) ? FREQ_MAX : quot[14:0];
  end

  pcfm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod_r),
    .divisor  (dt_r),
    .done     (div_done),
    .quotient (quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pcnt_r  <= '0;
      prev_r  <= 1'b0;
      last_r  <= '0;
      run_r   <= 1'b0;
      ovf_r   <= 1'b0;
      wsms_r  <= '0;
      wscnt_r <= '0;
      freq_r  <= '0;
    end else begin
      count_r <= count_nxt;
      pcnt_r  <= pcnt_nxt;
      prev_r  <= prev_nxt;
      last_r  <= last_nxt;
      run_r   <= run_nxt;
      ovf_r   <= ovf_nxt;
      wsms_r  <= wsms_nxt;
      wscnt_r <= wscnt_nxt;
      freq_r  <= freq_nxt;
    end
    if (cmd.ld_in) in_r <= in_data;
    delta_r <= delta_nxt;
    wrap_r  <= wrap_nxt;
    inwin_r <= inwin_nxt;
    stale_r <= stale_nxt;
    dt_r    <= dt_nxt;
    prod_r  <= prod_nxt;
    if (cmd.ld_out) begin
      out_r.count_value   <= 64'(count_r & mask);
      out_r.overflow_flag <= ovf_r;
      out_r.freq_hz       <= freq_r;
      out_r.is_running    <= run_r;
    end
  end

  assign sts.go_freq  = go_freq;
  assign sts.go_div   = go_div;
  assign sts.div_done = div_done;
  assign out_data     = out_r;
endmodule
`default_nettype wire

// ===== rtl/core/pcfm_ctrl.sv =====
// ---------------------------------------------------------------------------
// pcfm_ctrl
// Sequencer for one poll beat: step, frequency window, divide, hand over.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pcfm_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire pcfm_pkg::pcfm_sts_t sts,
  output pcfm_pkg::pcfm_cmd_t      cmd
);
  import pcfm_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_STEP  = 3'd1;
  localparam logic [2:0] S_FREQ  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_DGO   = 3'd5;
  localparam logic [2:0] S_DWAIT = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       ovld_r, ovld_nxt;
  logic       slot_free;

  assign slot_free = !ovld_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.ld_in = in_valid;
        if (in_valid) state_nxt = S_STEP;
      end
      S_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = sts.go_freq ? S_FREQ : S_FIN;
      end
      S_FREQ: begin
        cmd.freq  = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = sts.go_div ? S_MUL : S_FIN;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DGO;
      end
      S_DGO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DWAIT;
      end
      S_DWAIT: begin
        cmd.ld_freq = sts.div_done;
        if (sts.div_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        // hold until the output register is free
        cmd.ld_out = slot_free;
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign ovld_nxt = cmd.ld_out ? 1'b1 : (out_ready ? 1'b0 : ovld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ovld_r;
endmodule
`default_nettype wire

// ===== tb/sv/tb_pulse_counter_with_freq_meter.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_pulse_counter_with_freq_meter
// Self-checking bench for the polled pulse counter with frequency meter.
// Poll beats go in through a valid/ready sender with random idle bursts. An
// in-bench model of the channel works out each result beat, and a separate
// process compares every beat from the block against the oldest prediction.
// ---------------------------------------------------------------------------
module tb_pulse_counter_with_freq_meter;
  import pcfm_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  pcfm_in_t in_data;
  logic out_valid;
  logic out_ready;
  pcfm_out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [63:0] cfg_data;

  pulse_counter_with_freq_meter u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Register shadow, as the channel sees it
  logic        m_enabled;
  logic [1:0]  m_edge;
  logic        m_down;
  logic [1:0]  m_width;
  logic [7:0]  m_div;
  logic [63:0] m_start;
  logic [15:0] m_debounce;
  logic        m_freq_en;

  // Channel state
  logic [63:0] s_count;
  logic [7:0]  s_pre;
  logic        s_prev;
  logic [31:0] s_last_edge;
  logic        s_run;
  logic        s_ovf;
  logic [31:0] s_win_ms;
  logic [63:0] s_win_count;
  logic [14:0] s_freq;

  pcfm_out_t   expected_beats[$];
  int          errors;
  int          beats_sent;
  int          beats_seen;
  int          counted_steps;
  int          overflows;
  int          freq_updates;
  bit          quiet;        // no idling on either side
  bit          hold_off_req; // ask the receiver for one long stall
  logic [31:0] clock_ms;     // running timestamp used by the stimulus

  function automatic logic [63:0] count_mask();
    case (m_width)
      2'd0: return 64'hFF;
      2'd1: return 64'hFFFF;
      2'd2: return 64'hFFFF_FFFF;
      default: return '1;
    endcase
  endfunction

  function automatic void clear_window();
    s_win_ms = '0;
    s_win_count = '0;
    s_freq = '0;
  endfunction

  function automatic void measure_freq(input logic [31:0] now, input logic [63:0] maxv);
    logic [31:0] dt;
    logic [63:0] delta;
    logic [63:0] f;
    bit          keep;
    if (s_win_ms == 0) begin
      s_win_ms = now;
      s_win_count = s_count;
      s_freq = '0;
    end
    dt = now - s_win_ms;
    if (dt >= WIN_MIN && dt <= WIN_MAX) begin
      keep = 1'b1;
      if (s_count >= s_win_count) begin
        delta = s_count - s_win_count;
      end else begin
        delta = (maxv - s_win_count) + s_count + 64'd1;
        if (delta > maxv / 2) keep = 1'b0;
      end
      if (keep && delta <= DELTA_MAX) begin
        f = (delta * 64'd1000) / {32'd0, dt};
        if (f > 64'd20000) f = 64'd20000;
        s_freq = f[14:0];
        freq_updates++;
      end
      s_win_count = s_count;
      s_win_ms = now;
    end else if (dt > WIN_STALE) begin
      s_win_ms = now;
      s_win_count = s_count;
      s_freq = '0;
    end
  endfunction

  // Advance the channel model by one poll and return the result beat
  function automatic pcfm_out_t predict_poll(input pcfm_in_t p);
    pcfm_out_t   r;
    logic [63:0] maxv;
    logic [63:0] c;
    logic [7:0]  pre;
    logic [1:0]  e;
    bit          fire;
    bit          wrap;
    maxv = count_mask();
    if (m_enabled) begin
      if (p.command[CMD_RESET]) begin
        s_count = m_start & maxv;
        s_pre = '0;
        s_ovf = 1'b0;
        clear_window();
      end
      if (p.command[CMD_START]) s_run = 1'b1;
      if (p.command[CMD_STOP]) s_run = 1'b0;
      if (!s_run) begin
        s_prev = p.level;
      end else begin
        e = (m_edge > EDGE_BOTH) ? EDGE_RISE : m_edge;
        fire = (e == EDGE_RISE && !s_prev && p.level) ||
               (e == EDGE_FALL && s_prev && !p.level) ||
               (e == EDGE_BOTH && s_prev != p.level);
        s_prev = p.level;
        if (fire && (m_debounce == 0 || (p.now_ms - s_last_edge) >= {16'd0, m_debounce}))
        begin
          s_last_edge = p.now_ms;
          pre = (m_div == 0) ? 8'd1 : m_div;
          s_pre = s_pre + 8'd1;
          if (s_pre >= pre) begin
            s_pre = '0;
            counted_steps++;
            c = s_count & maxv;
            wrap = 1'b0;
            if (m_down) begin
              if (c == 0) wrap = 1'b1; else c = c - 1;
            end else begin
              if (c >= maxv) wrap = 1'b1; else c = c + 1;
            end
            s_count = c;
            if (wrap) begin
              s_ovf = 1'b1;
              s_count = m_start & maxv;
              clear_window();
              overflows++;
            end
            if (m_freq_en) measure_freq(p.now_ms, maxv);
          end
        end
      end
    end
    r.count_value = s_count & maxv;
    r.overflow_flag = s_ovf;
    r.freq_hz = s_freq;
    r.is_running = s_run;
    return r;
  endfunction

  // Idle burst now and then; drop valid while idling
  task automatic maybe_idle();
    int n;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Offer one poll beat and hold it until accepted; valid stays high for a
  // following beat and is dropped by the idler or the drain
  task automatic send_poll(input logic lvl, input logic [31:0] now, input logic [2:0] cmd);
    pcfm_in_t p;
    p.level = lvl;
    p.now_ms = now;
    p.command = cmd;
    maybe_idle();
    in_data <= p;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_beats.push_back(predict_poll(p));
    beats_sent++;
  endtask

  // Wait for all results, then let a measuring poll's latency run out
  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (expected_beats.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
  endtask

  // Offer one register write; valid is dropped by the caller after the last
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_CHANNEL_ENABLED: m_enabled = val[0];
      CFG_EDGE_SELECT:     m_edge = val[1:0];
      CFG_COUNT_DOWN:      m_down = val[0];
      CFG_WIDTH_CODE:      m_width = val[1:0];
      CFG_PRESCALE_DIV:    m_div = val[7:0];
      CFG_START_VALUE:     m_start = val;
      CFG_DEBOUNCE_MS:     m_debounce = val[15:0];
      CFG_FREQ_ENABLE:     m_freq_en = val[0];
      default: ;
    endcase
  endtask

  task automatic setup(input logic [1:0] e, input logic dn, input logic [1:0] w,
                       input logic [7:0] dv, input logic [63:0] sv,
                       input logic [15:0] db, input logic fe);
    drain();
    write_reg(CFG_CHANNEL_ENABLED, 64'd1);
    write_reg(CFG_EDGE_SELECT, {62'd0, e});
    write_reg(CFG_COUNT_DOWN, {63'd0, dn});
    write_reg(CFG_WIDTH_CODE, {62'd0, w});
    write_reg(CFG_PRESCALE_DIV, {56'd0, dv});
    write_reg(CFG_START_VALUE, sv);
    write_reg(CFG_DEBOUNCE_MS, {48'd0, db});
    write_reg(CFG_FREQ_ENABLE, {63'd0, fe});
    cfg_valid <= 1'b0;
  endtask

  // Square wave of random period; step the clock by a small random amount
  task automatic pulse_train(input int n, input int max_step, input int cmd_rate);
    logic       lvl;
    logic [2:0] cmd;
    lvl = 1'b0;
    for (int i = 0; i < n; i++) begin
      clock_ms = clock_ms + $urandom_range(1, max_step);
      lvl = ~lvl;
      cmd = ($urandom_range(0, 99) < cmd_rate) ? 3'($urandom_range(0, 7)) : 3'd0;
      send_poll(lvl, clock_ms, cmd);
    end
  endtask

  task automatic test_directed();
    // Disabled channel: commands ignored, only reports
    send_poll(1'b1, 32'd10, 3'b011);
    send_poll(1'b0, 32'hFFFF_FFFF, 3'b111);
    setup(EDGE_RISE, 1'b0, 2'd0, 8'd1, 64'hFFFF_FFFF_FFFF_FFFE, 16'd0, 1'b1);
    // Reset loads masked start value; stop wins over start
    send_poll(1'b0, 32'd0, 3'b111);
    send_poll(1'b0, 32'd1, 3'b011);
    // Rising edges at the top of 8 bits overflow and reload
    for (int i = 0; i < 4; i++) begin
      send_poll(1'b1, 32'd2 + 2 * i, 3'd0);
      send_poll(1'b0, 32'd3 + 2 * i, 3'd0);
    end
    // Count down at 64 bits with a long debounce, unused edge code 3, zero prescaler
    setup(2'd3, 1'b1, 2'd3, 8'd0, 64'h8000_0000_0000_0001, 16'd60000, 1'b0);
    send_poll(1'b0, 32'd100, 3'b011);
    send_poll(1'b1, 32'd200, 3'd0);
    send_poll(1'b0, 32'd300, 3'd0);
    send_poll(1'b1, 32'd70000, 3'd0);
    send_poll(1'b1, 32'hFFFF_FFFF, 3'b100);
    // Debounce across the timestamp wrap, both edges, counting down at 16 bits
    setup(EDGE_BOTH, 1'b1, 2'd1, 8'd255, 64'd0, 16'd5, 1'b1);
    send_poll(1'b1, 32'hFFFF_FFFE, 3'b011);
    send_poll(1'b0, 32'd3, 3'd0);
    send_poll(1'b1, 32'd8, 3'd0);
    drain();
    write_reg(CFG_PRESCALE_DIV, 64'd1);
    cfg_valid <= 1'b0;
    send_poll(1'b0, 32'd20, 3'd0);
    send_poll(1'b1, 32'd30, 3'b001);
  endtask

  task automatic test_freq_windows();
    clock_ms = 32'd1000;
    setup(EDGE_BOTH, 1'b0, 2'd2, 8'd1, 64'd0, 16'd0, 1'b1);
    send_poll(1'b0, clock_ms, 3'b011);
    pulse_train(150, 40, 1);
    // Long gaps land in the stale window branch
    pulse_train(20, 6000, 0);
    // Narrow width with frequent wrap-around in the measured window
    setup(EDGE_RISE, 1'b0, 2'd0, 8'd1, 64'd200, 16'd0, 1'b1);
    send_poll(1'b0, clock_ms, 3'b011);
    pulse_train(150, 30, 0);
    setup(EDGE_FALL, 1'b1, 2'd0, 8'd1, 64'd40, 16'd0, 1'b1);
    send_poll(1'b1, clock_ms, 3'b011);
    pulse_train(150, 30, 0);
  endtask

  task automatic test_backpressure();
    // Receiver stalls for a long stretch while polls keep coming
    hold_off_req = 1'b1;
    pulse_train(60, 20, 2);
    // Sender pauses until every result is back
    drain();
    pulse_train(40, 20, 2);
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 8; phase++) begin
      setup(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
            8'($urandom_range(0, 255) < 200 ? $urandom_range(1, 4) : $urandom_range(0, 255)),
            {$urandom, $urandom}, ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 60))
                                                             : 16'd0,
            1'($urandom_range(0, 1)));
      if (phase == 7) quiet = 1'b1;
      send_poll(1'b0, clock_ms, 3'b011);
      // Mostly well-formed pulse trains, some raw noise polls
      pulse_train(70, 60, 3);
      for (int i = 0; i < 12; i++)
        send_poll(1'($urandom_range(0, 1)), $urandom, 3'($urandom_range(0, 7)));
    end
  endtask

  // Result checker and receiver stalls
  initial begin
    int        hold;
    pcfm_out_t e;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        beats_seen++;
        if (expected_beats.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          e = expected_beats.pop_front();
          if (out_data.count_value !== e.count_value) begin
            $error("count_value exp %0h got %0h", e.count_value, out_data.count_value);
            errors++;
          end
          if (out_data.overflow_flag !== e.overflow_flag) begin
            $error("overflow_flag exp %0b got %0b", e.overflow_flag, out_data.overflow_flag);
            errors++;
          end
          if (out_data.freq_hz !== e.freq_hz) begin
            $error("freq_hz exp %0d got %0d", e.freq_hz, out_data.freq_hz);
            errors++;
          end
          if (out_data.is_running !== e.is_running) begin
            $error("is_running exp %0b got %0b", e.is_running, out_data.is_running);
            errors++;
          end
        end
      end
      // Choose next cycle's ready; one long hold-off when requested
      if (hold > 0) begin
        hold--;
        out_ready <= (hold == 0);
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold = 300;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 16);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    beats_sent = 0;
    beats_seen = 0;
    counted_steps = 0;
    overflows = 0;
    freq_updates = 0;
    quiet = 1'b0;
    hold_off_req = 1'b0;
    clock_ms = 32'd1000;
    m_enabled = 1'b0; m_edge = EDGE_RISE; m_down = 1'b0; m_width = WIDTH_RESET;
    m_div = 8'd1; m_start = '0; m_debounce = '0; m_freq_en = 1'b0;
    s_count = '0; s_pre = '0; s_prev = 1'b0; s_last_edge = '0; s_run = 1'b0;
    s_ovf = 1'b0; s_win_ms = '0; s_win_count = '0; s_freq = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_freq_windows();
    test_backpressure();
    test_random();
    drain();
    $display("Polls sent %0d, results checked %0d, count steps %0d", beats_sent,
             beats_seen, counted_steps);
    $display("Range wraps %0d, frequency readings %0d", overflows, freq_updates);
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== pulse_counter_with_freq_meter.f =====
+incdir+rtl/core
rtl/core/pcfm_pkg.sv
rtl/core/pcfm_div.sv
rtl/core/pcfm_dp.sv
rtl/core/pcfm_ctrl.sv
rtl/core/pulse_counter_with_freq_meter.sv
tb/sv/tb_pulse_counter_with_freq_meter.sv
